/* src/integer_to_ascii_formatter_core_macros.svh */
// Assertion macros for the integer to ASCII formatter core.
// Included by the RTL file that carries the concurrent checks; needs a clk and rst_n in scope.
`ifndef INTEGER_TO_ASCII_FORMATTER_CORE_MACROS_SVH
`define INTEGER_TO_ASCII_FORMATTER_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Condition that must hold in the same cycle as the trigger.
`define ITOA_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("itoa core: same-cycle check failed");
// Condition that must hold in the cycle after the trigger.
`define ITOA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("itoa core: next-cycle check failed");
`else
`define ITOA_ASSERT_SAME(lbl, ante, cons)
`define ITOA_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* src/itoa_pkg.sv */
// Shared types, codes and helpers for the integer to ASCII formatter core.
// No dependencies; used by itoa_digit_engine and integer_to_ascii_formatter_core.
`default_nettype none

package itoa_pkg;

  // Conversion modes. Bit 1 set selects hexadecimal, so the unused code acts as hex.
  localparam logic [1:0] OP_UDEC = 2'd0;
  localparam logic [1:0] OP_SDEC = 2'd1;
  localparam logic [1:0] OP_HEX  = 2'd2;
  localparam int unsigned OP_HEX_BIT = 1;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_A     = 8'h61;
  localparam logic [7:0] CHAR_MINUS = 8'h2d;
  localparam logic [3:0] DIGIT_TEN  = 4'd10;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] number;
  } in_req_t;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } out_req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SIGN,
    ST_CONV,
    ST_SKIP,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load_dec;
    logic load_hex;
    logic dabble;
    logic shift_out;
  } eng_ctrl_t;

  // ASCII code of one digit, 0-9 then lower-case a-f.
  function automatic logic [7:0] digit_to_ascii(input logic [3:0] d);
    logic [7:0] ch;
    if (d < DIGIT_TEN) begin
      ch = CHAR_ZERO + {4'd0, d};
    end else begin
      ch = CHAR_A + {4'd0, d - DIGIT_TEN};
    end
    return ch;
  endfunction

endpackage

`default_nettype wire

/* src/itoa_digit_engine.sv */
// Digit register and shift-add-3 unit of the integer to ASCII formatter core.
// Depends on itoa_pkg for the control struct.
`default_nettype none

module itoa_digit_engine #(
  parameter int VALUE_WIDTH = 32,
  parameter int NUM_DIGITS  = 10
) (
  input  wire logic                   clk,
  input  wire itoa_pkg::eng_ctrl_t    ctrl,
  input  wire logic [VALUE_WIDTH-1:0] load_value,
  output logic [3:0]                  top_digit
);

  localparam int DW = NUM_DIGITS * 4;

  logic [VALUE_WIDTH-1:0] bin_r, bin_nxt;
  logic [DW-1:0]          bcd_r, bcd_nxt;
  logic [DW-1:0]          bcd_adj;

  // Every digit of five or more gets three added before the shift.
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd_r[i*4 +: 4] >= 4'd5) begin
        bcd_adj[i*4 +: 4] = bcd_r[i*4 +: 4] + 4'd3;
      end else begin
        bcd_adj[i*4 +: 4] = bcd_r[i*4 +: 4];
      end
    end
  end

  always_comb begin
    bin_nxt = bin_r;
    bcd_nxt = bcd_r;
    if (ctrl.load_dec) begin
      bin_nxt = load_value;
      bcd_nxt = '0;
    end else if (ctrl.load_hex) begin
      bcd_nxt = {{(DW - VALUE_WIDTH){1'b0}}, load_value};
    end else if (ctrl.dabble) begin
      bcd_nxt = {bcd_adj[DW-2:0], bin_r[VALUE_WIDTH-1]};
      bin_nxt = {bin_r[VALUE_WIDTH-2:0], 1'b0};
    end else if (ctrl.shift_out) begin
      bcd_nxt = {bcd_r[DW-5:0], 4'd0};
    end
  end

  always_ff @(posedge clk) begin
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
  end

  assign top_digit = bcd_r[DW-1 -: 4];

endmodule

`default_nettype wire

/* src/integer_to_ascii_formatter_core.sv */
// Top level of the integer to ASCII formatter: request handshake, sequencer, output register.
// Depends on itoa_pkg, itoa_digit_engine and integer_to_ascii_formatter_core_macros.svh.
//
// A request (opcode, number) is taken at a rising edge with start high and busy low. The
// block then drives the ASCII text of the number one character per strobe on out_valid,
// most significant digit first, with out_data.last on the final character. Characters are
// shown for exactly one cycle each and the receiver cannot hold them off, so it must take
// every strobe. Decimal requests run a shift-add-3 conversion through the single digit
// engine, one bit per cycle, then the engine shifts leading zero digits away one per cycle
// and emits one digit per cycle; a negative signed request first sends a leading minus. A
// hexadecimal request skips the conversion. busy falls in the cycle the last character
// appears, so the next request may be given while that character is still on the output.
`default_nettype none
`include "integer_to_ascii_formatter_core_macros.svh"

module integer_to_ascii_formatter_core #(
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire itoa_pkg::in_req_t  in_data,
  output logic                    out_valid,
  output itoa_pkg::out_req_t      out_data
);

  // Decimal digits needed for VALUE_WIDTH bits: floor(VALUE_WIDTH * log10(2)) + 1.
  localparam int NUM_DIGITS = ((VALUE_WIDTH * 1233) >> 12) + 1;
  localparam int BIT_CNT_W  = $clog2(VALUE_WIDTH + 1);
  localparam int DIG_CNT_W  = $clog2(NUM_DIGITS + 1);

  itoa_pkg::state_t    state_r, state_nxt;
  logic [BIT_CNT_W-1:0] bit_cnt_r, bit_cnt_nxt;
  logic [DIG_CNT_W-1:0] dig_cnt_r, dig_cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  itoa_pkg::out_req_t   out_r, out_nxt;
  itoa_pkg::eng_ctrl_t  ctrl;
  logic [VALUE_WIDTH-1:0] value_w;
  logic [VALUE_WIDTH-1:0] load_value;
  logic [3:0]           top_digit;
  logic                 accept;
  logic                 is_hex;
  logic                 is_neg;

  // Only the low VALUE_WIDTH bits of the number count; a wider value is zero-extended.
  generate
    if (VALUE_WIDTH <= 32) begin : g_narrow
      assign value_w = in_data.number[VALUE_WIDTH-1:0];
    end else begin : g_wide
      assign value_w = {{(VALUE_WIDTH - 32){1'b0}}, in_data.number};
    end
  endgenerate

  assign accept = start && !busy;
  assign is_hex = in_data.opcode[itoa_pkg::OP_HEX_BIT];
  // Signed mode is exactly the signed code; the unused code already decoded as hex.
  assign is_neg = (in_data.opcode == itoa_pkg::OP_SDEC) && value_w[VALUE_WIDTH-1];
  // The two's complement of the most negative value is itself, read as unsigned.
  assign load_value = is_neg ? (~value_w + {{(VALUE_WIDTH - 1){1'b0}}, 1'b1}) : value_w;

  itoa_digit_engine #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .NUM_DIGITS  (NUM_DIGITS)
  ) u_engine (
    .clk        (clk),
    .ctrl       (ctrl),
    .load_value (load_value),
    .top_digit  (top_digit)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= itoa_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      bit_cnt_r   <= '0;
      dig_cnt_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      bit_cnt_r   <= bit_cnt_nxt;
      dig_cnt_r   <= dig_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    bit_cnt_nxt   = bit_cnt_r;
    dig_cnt_nxt   = dig_cnt_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    ctrl          = '0;
    case (state_r)
      itoa_pkg::ST_IDLE: begin
        if (accept) begin
          bit_cnt_nxt = BIT_CNT_W'(VALUE_WIDTH);
          dig_cnt_nxt = DIG_CNT_W'(NUM_DIGITS);
          if (is_hex) begin
            ctrl.load_hex = 1'b1;
            state_nxt     = itoa_pkg::ST_SKIP;
          end else begin
            ctrl.load_dec = 1'b1;
            state_nxt     = is_neg ? itoa_pkg::ST_SIGN : itoa_pkg::ST_CONV;
          end
        end
      end
      itoa_pkg::ST_SIGN: begin
        // The minus sign goes out while the conversion has not yet started.
        out_valid_nxt     = 1'b1;
        out_nxt.character = itoa_pkg::CHAR_MINUS;
        out_nxt.last      = 1'b0;
        state_nxt         = itoa_pkg::ST_CONV;
      end
      itoa_pkg::ST_CONV: begin
        ctrl.dabble = 1'b1;
        bit_cnt_nxt = bit_cnt_r - BIT_CNT_W'(1);
        if (bit_cnt_r == BIT_CNT_W'(1)) begin
          state_nxt = itoa_pkg::ST_SKIP;
        end
      end
      itoa_pkg::ST_SKIP: begin
        // Drop leading zeros, but always keep one digit so that zero prints as '0'.
        if ((top_digit == 4'd0) && (dig_cnt_r > DIG_CNT_W'(1))) begin
          ctrl.shift_out = 1'b1;
          dig_cnt_nxt    = dig_cnt_r - DIG_CNT_W'(1);
        end else begin
          state_nxt = itoa_pkg::ST_EMIT;
        end
      end
      itoa_pkg::ST_EMIT: begin
        ctrl.shift_out    = 1'b1;
        dig_cnt_nxt       = dig_cnt_r - DIG_CNT_W'(1);
        out_valid_nxt     = 1'b1;
        out_nxt.character = itoa_pkg::digit_to_ascii(top_digit);
        out_nxt.last      = (dig_cnt_r == DIG_CNT_W'(1));
        if (dig_cnt_r == DIG_CNT_W'(1)) begin
          state_nxt = itoa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = itoa_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy      = (state_r != itoa_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // A taken request always occupies the block in the following cycle.
  `ITOA_ASSERT_NEXT(a_accept_busy, accept, busy)
  // The final character appears exactly when the sequencer has gone back to idle.
  `ITOA_ASSERT_SAME(a_last_idle, out_valid && out_data.last, !busy)
  // Skipping leading zeros never produces a character.
  `ITOA_ASSERT_NEXT(a_skip_quiet, state_r == itoa_pkg::ST_SKIP, !out_valid)
  // The emit phase always has at least one digit left to send.
  `ITOA_ASSERT_SAME(a_emit_count, state_r == itoa_pkg::ST_EMIT, dig_cnt_r != '0)

endmodule

`default_nettype wire
